// ----- rtl/sida_pkg.sv -----
// Shared constants and types for the signed integer to decimal text converter.
package sida_pkg;

	localparam int VALUE_W       = 32;
	localparam int NUM_DIGITS    = 10;
	localparam int BITS_PER_STEP = 4;
	localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
	localparam int DIGIT_W       = 4;
	localparam int CHAR_W        = 6;
	localparam int CNT_W         = $clog2(CONV_STEPS);
	localparam int REM_W         = $clog2(NUM_DIGITS + 1);

	localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_SKIP,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		CM_HOLD,
		CM_CLEAR,
		CM_DABBLE,
		CM_SHIFT
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		logic       mag_load;
		logic       mag_shift;
		logic       sign_sel;
	} ctl_t;

endpackage

// ----- rtl/signed_int_to_decimal_ascii.sv -----
// Top level: signed 32-bit integer to decimal ASCII character stream.
// One request carries a 32-bit two's complement value; the block answers with
// its decimal text, a leading '-' for negative values, no leading zeros, '0'
// for zero, one character per output transfer, tlast on the final one. One
// value is in flight at a time: after acceptance the magnitude is fed four
// bits per cycle into a chain of ten BCD digit cells, leading zero digits are
// shifted out of the top cell one per cycle, then each character leaves from the
// top cell as it is taken.
module signed_int_to_decimal_ascii import sida_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [5:0] char_code, [7:6] zero
	output logic        m_tlast    // last
);

	ctl_t                     ctl;
	logic [VALUE_W-1:0]       mag_q;
	logic [BITS_PER_STEP-1:0] carry [NUM_DIGITS+1];
	logic [DIGIT_W-1:0]       dig   [NUM_DIGITS+1];
	logic [CHAR_W-1:0]        char_code;
	logic                     negative;
	logic                     top_zero;

	assign negative = s_tdata[VALUE_W-1];

	always_ff @(posedge clk) begin
		if (ctl.mag_load) begin
			mag_q <= negative ? (VALUE_W'(0) - s_tdata) : s_tdata;
		end else if (ctl.mag_shift) begin
			mag_q <= {mag_q[VALUE_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
		end
	end

	assign carry[0] = mag_q[VALUE_W-1 -: BITS_PER_STEP];
	assign dig[0]   = '0;

	for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
		sida_cell u_cell (
			.clk      (clk),
			.mode     (ctl.mode),
			.bits_in  (carry[i]),
			.digit_in (dig[i]),
			.bits_out (carry[i+1]),
			.digit    (dig[i+1])
		);
	end

	assign top_zero = (dig[NUM_DIGITS] == '0);

	sida_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.negative (negative),
		.top_zero (top_zero),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tlast  (m_tlast),
		.ctl      (ctl)
	);

	assign char_code = ctl.sign_sel ? CHAR_MINUS
		: CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, dig[NUM_DIGITS]};
	assign m_tdata = {{(8-CHAR_W){1'b0}}, char_code};

endmodule

// ----- rtl/sida_cell.sv -----
// One BCD digit cell: shift-and-add-3 conversion, then digit shift toward the top.
module sida_cell import sida_pkg::*; (
	input  logic                     clk,
	input  cell_mode_t               mode,
	input  logic [BITS_PER_STEP-1:0] bits_in,   // from lower cell, MSB enters first
	input  logic [DIGIT_W-1:0]       digit_in,  // lower cell's digit, for shift-out
	output logic [BITS_PER_STEP-1:0] bits_out,  // to upper cell, MSB leaves first
	output logic [DIGIT_W-1:0]       digit
);

	logic [DIGIT_W-1:0] digit_q;
	logic [DIGIT_W-1:0] dabble_d;

	always_comb begin
		logic [DIGIT_W-1:0] d;
		d = digit_q;
		bits_out = '0;
		for (int k = 0; k < BITS_PER_STEP; k++) begin
			if (d >= 4'd5) begin
				d = d + 4'd3;
			end
			bits_out[BITS_PER_STEP-1-k] = d[DIGIT_W-1];
			d = {d[DIGIT_W-2:0], bits_in[BITS_PER_STEP-1-k]};
		end
		dabble_d = d;
	end

	always_ff @(posedge clk) begin
		case (mode)
			CM_CLEAR:  digit_q <= '0;
			CM_DABBLE: digit_q <= dabble_d;
			CM_SHIFT:  digit_q <= digit_in;
			default:   digit_q <= digit_q;
		endcase
	end

	assign digit = digit_q;

endmodule

// ----- rtl/sida_ctrl.sv -----
// Sequencer: conversion count, leading zero skip and character handshake.
module sida_ctrl import sida_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  logic negative,
	input  logic top_zero,
	output logic m_tvalid,
	input  logic m_tready,
	output logic m_tlast,
	output ctl_t ctl
);

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q;
	logic [REM_W-1:0] rem_q;
	logic             neg_q;
	logic             rem_one;
	logic             conv_done;

	assign rem_one   = (rem_q == REM_W'(1));
	assign conv_done = (cnt_q == CNT_W'(CONV_STEPS - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (s_tvalid) begin
				state_d = ST_CONV;
			end
			ST_CONV: if (conv_done) begin
				state_d = neg_q ? ST_SIGN : ST_SKIP;
			end
			ST_SIGN: if (m_tready) begin
				state_d = ST_SKIP;
			end
			ST_SKIP: if (!top_zero || rem_one) begin
				state_d = ST_EMIT;
			end
			ST_EMIT: if (m_tready && rem_one) begin
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready      = 1'b0;
		m_tvalid      = 1'b0;
		m_tlast       = 1'b0;
		ctl.mode      = CM_HOLD;
		ctl.mag_load  = 1'b0;
		ctl.mag_shift = 1'b0;
		ctl.sign_sel  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready     = 1'b1;
				ctl.mag_load = s_tvalid;
				ctl.mode     = s_tvalid ? CM_CLEAR : CM_HOLD;
			end
			ST_CONV: begin
				ctl.mode      = CM_DABBLE;
				ctl.mag_shift = 1'b1;
			end
			ST_SIGN: begin
				m_tvalid     = 1'b1;
				ctl.sign_sel = 1'b1;
			end
			ST_SKIP: begin
				ctl.mode = (top_zero && !rem_one) ? CM_SHIFT : CM_HOLD;
			end
			ST_EMIT: begin
				m_tvalid = 1'b1;
				m_tlast  = rem_one;
				ctl.mode = (m_tready && !rem_one) ? CM_SHIFT : CM_HOLD;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rem_q   <= REM_W'(NUM_DIGITS);
			neg_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (s_tvalid) begin
						neg_q <= negative;
					end
				end
				ST_CONV: begin
					cnt_q <= cnt_q + CNT_W'(1);
					rem_q <= REM_W'(NUM_DIGITS);
				end
				ST_SKIP: if (top_zero && !rem_one) begin
					rem_q <= rem_q - REM_W'(1);
				end
				ST_EMIT: if (m_tready && !rem_one) begin
					rem_q <= rem_q - REM_W'(1);
				end
				default: ;
			endcase
		end
	end

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input taken while a character is offered");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken during conversion");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("block not idle after final character");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SKIP || state_q == ST_EMIT) |->
			(rem_q != '0 && rem_q <= REM_W'(NUM_DIGITS)))
		else $error("digit count out of range");

	a_sign_first: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && ctl.sign_sel) |-> (!m_tlast && neg_q))
		else $error("minus sign offered for a non-negative value or as last");

endmodule
